// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator package
// Transaction types, status and request codes, and the sequencer states.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOM  = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_bytes;
        logic [15:0] free_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] data_offset;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_A_SPLIT,
        ST_A_AFTER,
        ST_A_MARK,
        ST_F_RD,
        ST_F_CHK,
        ST_F_PRD,
        ST_F_PCHK,
        ST_F_PAFTER,
        ST_F_PCLR,
        ST_F_NRD,
        ST_F_NCHK,
        ST_F_NAFTER,
        ST_F_NCLR,
        ST_RESP
    } state_t;

endpackage

// ----- design/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// First-fit heap allocator
// Allocates and frees blocks of a granule arena, walking the address-ordered
// block chain one block at a time, reading then checking each, and coalescing free neighbours.
// ----------------------------------------------------------------------------
// An allocation reads and checks each block visited, then may split the fitting
// block and marks it busy; a free checks its block, then merges free neighbours.
// One request is in flight at a time; the walk through the block memory sets
// the rate, so throughput falls with the number of blocks in the arena.
// After reset a clearing pass writes every granule of the block memories in turn,
// during which no request is accepted.
module first_fit_heap_allocator #(
    parameter int ARENA_GRANULES  = 4096,
    parameter int HEADER_GRANULES = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  ffha_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output ffha_pkg::rsp_t  rsp
);

    localparam int IW  = $clog2(ARENA_GRANULES);
    localparam int GW  = $clog2(ARENA_GRANULES + 1);
    localparam int CW  = ((GW > 14) ? GW : 14) + 1;
    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_GRANULES);
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_GRANULES);
    localparam logic [CW-1:0] MIN_C   = CW'(HEADER_GRANULES + 1);
    localparam logic [GW-1:0] NONE_G  = GW'(ARENA_GRANULES);

    logic [GW-1:0] size_mem [ARENA_GRANULES];
    logic [1:0]    flag_mem [ARENA_GRANULES];
    logic [GW-1:0] pred_mem [ARENA_GRANULES];

    logic          size_we, flag_we, pred_we;
    logic [IW-1:0] size_wa, flag_wa, pred_wa;
    logic [GW-1:0] size_wd, pred_wd;
    logic [1:0]    flag_wd;
    logic          rd_en;
    logic [IW-1:0] rd_addr;

    logic [GW-1:0] rd_size_reg;
    logic          rd_busy_reg, rd_begins_reg;
    logic [GW-1:0] rd_pred_reg;

    ffha_pkg::state_t state_reg, state_next;
    logic [CW-1:0] g_reg, g_next;
    logic [CW-1:0] sz_reg, sz_next;
    logic [CW-1:0] need_reg, need_next;
    logic [CW-1:0] aux_reg, aux_next;
    logic [GW-1:0] clr_reg, clr_next;
    ffha_pkg::rsp_t res_reg, res_next;
    ffha_pkg::rsp_t rsp_reg;
    logic          rsp_valid_reg;
    logic          rsp_load;

    logic [CW-1:0] rd_size_c;
    logic [CW-1:0] req_need;
    logic [16:0]   req_round;
    logic [11:0]   free_gran;
    logic [CW-1:0] free_g;
    logic          free_bad;
    logic [CW+3:0] offs;

    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[size_wa] <= size_wd;
        end
        if (flag_we)
        begin
            flag_mem[flag_wa] <= flag_wd;
        end
        if (pred_we)
        begin
            pred_mem[pred_wa] <= pred_wd;
        end
        if (rd_en)
        begin
            rd_size_reg                  <= size_mem[rd_addr];
            {rd_busy_reg, rd_begins_reg} <= flag_mem[rd_addr];
            rd_pred_reg                  <= pred_mem[rd_addr];
        end
    end

    assign rd_size_c = CW'(rd_size_reg);
    assign req_round = (17'(req.request_bytes) + 17'd15) >> 4;
    assign req_need  = (CW'(req_round) + HDR_C < MIN_C) ? MIN_C : CW'(req_round) + HDR_C;
    assign free_gran = req.free_offset[15:4];
    assign free_g    = CW'(free_gran) - HDR_C;
    assign free_bad  = (req.free_offset[3:0] != 4'd0) || (CW'(free_gran) < HDR_C)
                       || (free_g >= ARENA_C);
    assign offs      = {g_reg + HDR_C, 4'b0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::ST_CLEAR;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg    <= g_next;
        sz_reg   <= sz_next;
        need_reg <= need_next;
        aux_reg  <= aux_next;
        res_reg  <= res_next;
        if (rsp_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        g_next     = g_reg;
        sz_next    = sz_reg;
        need_next  = need_reg;
        aux_next   = aux_reg;
        clr_next   = clr_reg;
        res_next   = res_reg;
        size_we    = 1'b0;
        flag_we    = 1'b0;
        pred_we    = 1'b0;
        size_wa    = g_reg[IW-1:0];
        flag_wa    = g_reg[IW-1:0];
        pred_wa    = g_reg[IW-1:0];
        size_wd    = '0;
        flag_wd    = 2'b00;
        pred_wd    = NONE_G;
        rd_en      = 1'b0;
        rd_addr    = g_reg[IW-1:0];
        rsp_load   = 1'b0;
        req_stall  = 1'b1;

        unique case (state_reg)
            ffha_pkg::ST_CLEAR:
            begin
                size_we = 1'b1;
                flag_we = 1'b1;
                pred_we = 1'b1;
                size_wa = clr_reg[IW-1:0];
                flag_wa = clr_reg[IW-1:0];
                pred_wa = clr_reg[IW-1:0];
                size_wd = (clr_reg == '0) ? NONE_G : '0;
                flag_wd = (clr_reg == '0) ? 2'b01 : 2'b00;
                clr_next = clr_reg + GW'(1);
                if (clr_reg == NONE_G - GW'(1))
                begin
                    state_next = ffha_pkg::ST_IDLE;
                end
            end
            ffha_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    res_next.data_offset = 16'd0;
                    if (req.kind == ffha_pkg::KIND_ALLOC)
                    begin
                        need_next  = req_need;
                        g_next     = '0;
                        state_next = ffha_pkg::ST_A_RD;
                    end
                    else if (free_bad)
                    begin
                        res_next.status = ffha_pkg::STATUS_BAD;
                        state_next      = ffha_pkg::ST_RESP;
                    end
                    else
                    begin
                        g_next     = free_g;
                        state_next = ffha_pkg::ST_F_RD;
                    end
                end
            end
            ffha_pkg::ST_A_RD:
            begin
                if (g_reg >= ARENA_C)
                begin
                    res_next.status = ffha_pkg::STATUS_OOM;
                    state_next      = ffha_pkg::ST_RESP;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = ffha_pkg::ST_A_CHK;
                end
            end
            ffha_pkg::ST_A_CHK:
            begin
                if (!rd_begins_reg || rd_size_reg == '0)
                begin
                    res_next.status = ffha_pkg::STATUS_OOM;
                    state_next      = ffha_pkg::ST_RESP;
                end
                else if (!rd_busy_reg && rd_size_c >= need_reg)
                begin
                    sz_next = rd_size_c;
                    if (rd_size_c >= need_reg + MIN_C)
                    begin
                        state_next = ffha_pkg::ST_A_SPLIT;
                    end
                    else
                    begin
                        state_next = ffha_pkg::ST_A_MARK;
                    end
                end
                else
                begin
                    g_next     = g_reg + rd_size_c;
                    state_next = ffha_pkg::ST_A_RD;
                end
            end
            ffha_pkg::ST_A_SPLIT:
            begin
                size_we    = 1'b1;
                flag_we    = 1'b1;
                pred_we    = 1'b1;
                size_wa    = IW'(g_reg + need_reg);
                flag_wa    = IW'(g_reg + need_reg);
                pred_wa    = IW'(g_reg + need_reg);
                size_wd    = GW'(sz_reg - need_reg);
                flag_wd    = 2'b01;
                pred_wd    = GW'(g_reg);
                state_next = ffha_pkg::ST_A_AFTER;
            end
            ffha_pkg::ST_A_AFTER:
            begin
                size_we    = 1'b1;
                size_wd    = GW'(need_reg);
                pred_we    = (g_reg + sz_reg) < ARENA_C;
                pred_wa    = IW'(g_reg + sz_reg);
                pred_wd    = GW'(g_reg + need_reg);
                state_next = ffha_pkg::ST_A_MARK;
            end
            ffha_pkg::ST_A_MARK:
            begin
                flag_we              = 1'b1;
                flag_wd              = 2'b11;
                res_next.status      = ffha_pkg::STATUS_OK;
                res_next.data_offset = offs[15:0];
                state_next           = ffha_pkg::ST_RESP;
            end
            ffha_pkg::ST_F_RD:
            begin
                rd_en      = 1'b1;
                state_next = ffha_pkg::ST_F_CHK;
            end
            ffha_pkg::ST_F_CHK:
            begin
                if (!rd_begins_reg || !rd_busy_reg)
                begin
                    res_next.status = ffha_pkg::STATUS_BAD;
                    state_next      = ffha_pkg::ST_RESP;
                end
                else
                begin
                    flag_we  = 1'b1;
                    flag_wd  = 2'b01;
                    sz_next  = rd_size_c;
                    aux_next = CW'(rd_pred_reg);
                    if (CW'(rd_pred_reg) < ARENA_C)
                    begin
                        state_next = ffha_pkg::ST_F_PRD;
                    end
                    else
                    begin
                        state_next = ffha_pkg::ST_F_NRD;
                    end
                end
            end
            ffha_pkg::ST_F_PRD:
            begin
                rd_en      = 1'b1;
                rd_addr    = aux_reg[IW-1:0];
                state_next = ffha_pkg::ST_F_PCHK;
            end
            ffha_pkg::ST_F_PCHK:
            begin
                if (rd_busy_reg)
                begin
                    state_next = ffha_pkg::ST_F_NRD;
                end
                else
                begin
                    size_we    = 1'b1;
                    size_wa    = aux_reg[IW-1:0];
                    size_wd    = GW'(rd_size_c + sz_reg);
                    need_next  = rd_size_c + sz_reg;
                    state_next = ffha_pkg::ST_F_PAFTER;
                end
            end
            ffha_pkg::ST_F_PAFTER:
            begin
                pred_we    = (g_reg + sz_reg) < ARENA_C;
                pred_wa    = IW'(g_reg + sz_reg);
                pred_wd    = GW'(aux_reg);
                state_next = ffha_pkg::ST_F_PCLR;
            end
            ffha_pkg::ST_F_PCLR:
            begin
                size_we    = 1'b1;
                flag_we    = 1'b1;
                pred_we    = 1'b1;
                g_next     = aux_reg;
                sz_next    = need_reg;
                state_next = ffha_pkg::ST_F_NRD;
            end
            ffha_pkg::ST_F_NRD:
            begin
                aux_next = g_reg + sz_reg;
                if ((g_reg + sz_reg) < ARENA_C)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IW'(g_reg + sz_reg);
                    state_next = ffha_pkg::ST_F_NCHK;
                end
                else
                begin
                    res_next.status = ffha_pkg::STATUS_OK;
                    state_next      = ffha_pkg::ST_RESP;
                end
            end
            ffha_pkg::ST_F_NCHK:
            begin
                if (rd_begins_reg && !rd_busy_reg)
                begin
                    size_we    = 1'b1;
                    size_wd    = GW'(sz_reg + rd_size_c);
                    need_next  = rd_size_c;
                    state_next = ffha_pkg::ST_F_NAFTER;
                end
                else
                begin
                    res_next.status = ffha_pkg::STATUS_OK;
                    state_next      = ffha_pkg::ST_RESP;
                end
            end
            ffha_pkg::ST_F_NAFTER:
            begin
                pred_we    = (aux_reg + need_reg) < ARENA_C;
                pred_wa    = IW'(aux_reg + need_reg);
                pred_wd    = GW'(g_reg);
                state_next = ffha_pkg::ST_F_NCLR;
            end
            ffha_pkg::ST_F_NCLR:
            begin
                size_we         = 1'b1;
                flag_we         = 1'b1;
                pred_we         = 1'b1;
                size_wa         = aux_reg[IW-1:0];
                flag_wa         = aux_reg[IW-1:0];
                pred_wa         = aux_reg[IW-1:0];
                res_next.status = ffha_pkg::STATUS_OK;
                state_next      = ffha_pkg::ST_RESP;
            end
            ffha_pkg::ST_RESP:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_load   = 1'b1;
                    state_next = ffha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
